>>> hw/rtl/tcfq_pkg.sv
// ----------------------------------------------------------------------------
// tcfq_pkg - shared types and constants for the two-class fifo
// sizes, command and status codes, beat structs for the command and
// result channels, and the ring control/status structs
// ----------------------------------------------------------------------------
package tcfq_pkg;

    localparam int CLASS_DEPTH = 16;
    localparam int STAMP_BITS  = 16;

    localparam int AGE_W   = 10;
    localparam int OSTMP_W = 16;
    localparam int PTR_W   = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CNT_W   = $clog2(CLASS_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    localparam logic [1:0] OP_ENQ     = 2'd0;
    localparam logic [1:0] OP_DEQ_ANY = 2'd1;
    localparam logic [1:0] OP_DEQ_C0  = 2'd2;
    localparam logic [1:0] OP_DEQ_C1  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic KIND_DOG = 1'b0;
    localparam logic KIND_CAT = 1'b1;

    typedef struct packed {
        logic [1:0]       operation;
        logic             kind;
        logic [AGE_W-1:0] age;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic               out_kind;
        logic [AGE_W-1:0]   out_age;
        logic [OSTMP_W-1:0] out_stamp;
    } t_result;

    typedef struct packed {
        logic [AGE_W-1:0]      age;
        logic [STAMP_BITS-1:0] stamp;
    } t_slot;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_stat;

    // low bits of the stamp as shown on the result port
    function automatic logic [OSTMP_W-1:0] out_stamp_of(input logic [STAMP_BITS-1:0] s);
        logic [31:0] wide;
        wide = 32'(s);
        return wide[OSTMP_W-1:0];
    endfunction

endpackage

>>> hw/rtl/tcfq_ring.sv
// ----------------------------------------------------------------------------
// tcfq_ring - one class ring
// circular store of age/stamp slots with head pointer and fill count;
// head slot is read combinationally, push writes at head + count
// ----------------------------------------------------------------------------
module tcfq_ring (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcfq_pkg::t_ring_ctl   i_ctl,
    input  tcfq_pkg::t_slot       i_data,
    output tcfq_pkg::t_slot       o_head,
    output tcfq_pkg::t_ring_stat  o_stat
);

    tcfq_pkg::t_slot               r_mem [tcfq_pkg::CLASS_DEPTH];
    logic [tcfq_pkg::PTR_W-1:0]    r_head, n_head;
    logic [tcfq_pkg::CNT_W-1:0]    r_count, n_count;
    logic [tcfq_pkg::SUM_W-1:0]    w_sum;
    logic [tcfq_pkg::PTR_W-1:0]    w_tail;

    // head + count wraps at most once
    always_comb begin
        w_sum = tcfq_pkg::SUM_W'(r_head) + tcfq_pkg::SUM_W'(r_count);
        if (w_sum >= tcfq_pkg::SUM_W'(tcfq_pkg::CLASS_DEPTH)) begin
            w_sum = w_sum - tcfq_pkg::SUM_W'(tcfq_pkg::CLASS_DEPTH);
        end
        w_tail = w_sum[tcfq_pkg::PTR_W-1:0];
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + tcfq_pkg::CNT_W'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - tcfq_pkg::CNT_W'(1);
            if (r_head == tcfq_pkg::PTR_W'(tcfq_pkg::CLASS_DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + tcfq_pkg::PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[w_tail] <= i_data;
        end
    end

    assign o_head       = r_mem[r_head];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == tcfq_pkg::CNT_W'(tcfq_pkg::CLASS_DEPTH));

endmodule

>>> hw/rtl/two_class_fifo_oldest_dequeue.sv
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_dequeue - two-class fifo with oldest-first dequeue
// ----------------------------------------------------------------------------
// Command channel: a beat is taken at a rising edge with start high and busy
// low. busy stays low, so a command can be issued in every cycle. A command
// either enqueues an entry (class, age) or dequeues the oldest entry of any
// class, of class 0 or of class 1.
// Result channel: every command gives exactly one result beat, shown for one
// cycle with o_valid high, behind the command and result registers. The
// receiver cannot stall; results are produced at one per cycle.
// Each class lives in its own ring of CLASS_DEPTH slots; an accepted enqueue
// is stamped from an arrival counter it advances. Dequeue-any compares the
// two head stamps with wraparound arithmetic, class 0 winning ties.
// The per-command work is one pass of ring status, head compare and pointer
// update between the command register and the result register.
// Reset (synchronous, active low) empties both rings, clears the arrival
// counter and drops any command or result in flight; slot contents are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_dequeue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tcfq_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output tcfq_pkg::t_result o_result
);

    tcfq_pkg::t_cmd                  r_cmd;
    logic                            r_cmd_vld;
    logic [tcfq_pkg::STAMP_BITS-1:0] r_stamp, n_stamp;
    tcfq_pkg::t_result               r_res, n_res;
    logic                            r_res_vld;

    tcfq_pkg::t_ring_ctl             w_ctl0, w_ctl1;
    tcfq_pkg::t_ring_stat            w_stat0, w_stat1;
    tcfq_pkg::t_slot                 w_head0, w_head1, w_new;
    logic [tcfq_pkg::STAMP_BITS-1:0] w_diff;
    logic                            w_old0;
    logic                            w_pick1;
    logic                            w_pop;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
            r_res_vld <= 1'b0;
            r_stamp   <= '0;
        end else begin
            r_cmd_vld <= start && !busy;
            r_res_vld <= r_cmd_vld;
            r_stamp   <= n_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        r_res <= n_res;
    end

    tcfq_ring u_ring0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl0),
        .i_data  (w_new),
        .o_head  (w_head0),
        .o_stat  (w_stat0)
    );

    tcfq_ring u_ring1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl1),
        .i_data  (w_new),
        .o_head  (w_head1),
        .o_stat  (w_stat1)
    );

    // class 0 is older when s0 - s1 is zero or negative in serial arithmetic
    assign w_diff = w_head0.stamp - w_head1.stamp;
    assign w_old0 = (w_diff == '0) || w_diff[tcfq_pkg::STAMP_BITS-1];

    assign w_new.age   = r_cmd.age;
    assign w_new.stamp = r_stamp;

    always_comb begin
        w_ctl0  = '0;
        w_ctl1  = '0;
        n_stamp = r_stamp;
        n_res   = '0;
        w_pick1 = 1'b0;
        w_pop   = 1'b0;
        if (r_cmd_vld) begin
            case (r_cmd.operation)
                tcfq_pkg::OP_ENQ: begin
                    if ((r_cmd.kind == tcfq_pkg::KIND_CAT) ? w_stat1.full : w_stat0.full) begin
                        n_res.status = tcfq_pkg::ST_FULL;
                    end else begin
                        w_ctl0.push = (r_cmd.kind == tcfq_pkg::KIND_DOG);
                        w_ctl1.push = (r_cmd.kind == tcfq_pkg::KIND_CAT);
                        n_stamp     = r_stamp + tcfq_pkg::STAMP_BITS'(1);
                    end
                end
                tcfq_pkg::OP_DEQ_ANY: begin
                    w_pop   = !(w_stat0.empty && w_stat1.empty);
                    w_pick1 = w_stat0.empty || (!w_stat1.empty && !w_old0);
                end
                tcfq_pkg::OP_DEQ_C0: begin
                    w_pop   = !w_stat0.empty;
                    w_pick1 = 1'b0;
                end
                tcfq_pkg::OP_DEQ_C1: begin
                    w_pop   = !w_stat1.empty;
                    w_pick1 = 1'b1;
                end
                default: begin
                    w_pop = 1'b0;
                end
            endcase
            if (r_cmd.operation != tcfq_pkg::OP_ENQ) begin
                if (w_pop) begin
                    w_ctl0.pop     = !w_pick1;
                    w_ctl1.pop     = w_pick1;
                    n_res.status   = tcfq_pkg::ST_DONE;
                    n_res.out_kind = w_pick1 ? tcfq_pkg::KIND_CAT : tcfq_pkg::KIND_DOG;
                    n_res.out_age  = w_pick1 ? w_head1.age : w_head0.age;
                    n_res.out_stamp = tcfq_pkg::out_stamp_of(
                        w_pick1 ? w_head1.stamp : w_head0.stamp);
                end else begin
                    n_res.status = tcfq_pkg::ST_EMPTY;
                end
            end
        end
    end

    assign o_valid  = r_res_vld;
    assign o_result = r_res;

endmodule

>>> hw/rtl/tcfq_checker.sv
// ----------------------------------------------------------------------------
// tcfq_checker - port-level checks for the two-class fifo
// one result beat per command at fixed latency, and zeroed result fields
// where nothing was removed
// ----------------------------------------------------------------------------
module tcfq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input tcfq_pkg::t_cmd    i_cmd,
    input logic              o_valid,
    input tcfq_pkg::t_result o_result
);

    // every command beat is followed by a result beat
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("command beat without result beat");

    // no result beat without a command beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result beat without command beat");

    // only an enqueue can report full
    a_full_from_enq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == tcfq_pkg::ST_FULL)
            |-> $past(i_cmd.operation, 2) == tcfq_pkg::OP_ENQ)
        else $error("full status on a dequeue");

    // enqueue and empty results carry no entry
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != tcfq_pkg::ST_DONE
                     || $past(i_cmd.operation, 2) == tcfq_pkg::OP_ENQ))
            |-> (o_result.out_kind == 1'b0 && o_result.out_age == '0
                 && o_result.out_stamp == '0))
        else $error("result fields set with no entry removed");

endmodule

bind two_class_fifo_oldest_dequeue tcfq_checker u_tcfq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_result (o_result)
);

>>> sim/tcfq_order_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcfq_order_checker - result checker for the two-class fifo
// Watches the command and result channels. Keeps its own copy of both class
// rings and the arrival counter, works out the result of each accepted
// command and compares every result beat, field by field, against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tcfq_order_checker
    import tcfq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_cmd    i_cmd,
    input  logic    i_valid,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending
);

    t_slot                 rings [2][CLASS_DEPTH];
    logic [PTR_W-1:0]      head [2];
    int unsigned           fill [2];
    logic [STAMP_BITS-1:0] arrival;
    t_result               owed_results [$];
    int                    mismatches = 0;

    function automatic t_result take_head(input logic k);
        t_result r;
        t_slot   s;
        s = rings[k][head[k]];
        head[k] = PTR_W'((int'(head[k]) + 1) % CLASS_DEPTH);
        fill[k]--;
        r = '0;
        r.status    = ST_DONE;
        r.out_kind  = k;
        r.out_age   = s.age;
        r.out_stamp = OSTMP_W'(s.stamp);
        return r;
    endfunction

    function automatic t_result next_outcome(input t_cmd c);
        t_result               r;
        t_slot                 s;
        logic [STAMP_BITS-1:0] stamp_gap;
        int unsigned           tail;
        logic                  k;
        r = '0;
        case (c.operation)
            OP_ENQ: begin
                k = c.kind;
                if (fill[k] >= CLASS_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    tail = (32'(head[k]) + fill[k]) % CLASS_DEPTH;
                    s.age   = c.age;
                    s.stamp = arrival;
                    rings[k][tail] = s;
                    fill[k]++;
                    arrival = arrival + STAMP_BITS'(1);
                end
            end
            OP_DEQ_ANY: begin
                if (fill[0] == 0 && fill[1] == 0) begin
                    r.status = ST_EMPTY;
                end else if (fill[1] == 0) begin
                    r = take_head(KIND_DOG);
                end else if (fill[0] == 0) begin
                    r = take_head(KIND_CAT);
                end else begin
                    // serial-number compare, dog wins a tie
                    stamp_gap = rings[0][head[0]].stamp - rings[1][head[1]].stamp;
                    if (stamp_gap == '0 || stamp_gap[STAMP_BITS-1])
                        r = take_head(KIND_DOG);
                    else
                        r = take_head(KIND_CAT);
                end
            end
            OP_DEQ_C0, OP_DEQ_C1: begin
                k = (c.operation == OP_DEQ_C0) ? KIND_DOG : KIND_CAT;
                if (fill[k] == 0)
                    r.status = ST_EMPTY;
                else
                    r = take_head(k);
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic int field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                head[k] = '0;
                fill[k] = 0;
            end
            arrival = '0;
            owed_results.delete();
        end else begin
            if (i_start && !i_busy)
                owed_results.push_back(next_outcome(i_cmd));
            if (i_valid) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result beat with nothing owed, expected none actual %h",
                             $time, i_result);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    mismatches += field_diff("status", 32'(want.status), 32'(i_result.status));
                    mismatches += field_diff("out_kind", 32'(want.out_kind),
                                             32'(i_result.out_kind));
                    mismatches += field_diff("out_age", 32'(want.out_age),
                                             32'(i_result.out_age));
                    mismatches += field_diff("out_stamp", 32'(want.out_stamp),
                                             32'(i_result.out_stamp));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= owed_results.size();
    end

endmodule

>>> sim/tb_two_class_fifo_oldest_dequeue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_class_fifo_oldest_dequeue - testbench for the two-class fifo
// Drives commands in random bursts: a directed opening (empty dequeues,
// oldest-first ordering, ignored kind on dequeue, a full class), then
// random fill and drain phases, then an enqueue/dequeue run that starts
// with both classes holding entries. A separate checker predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module tb_two_class_fifo_oldest_dequeue;
    import tcfq_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CHURN_PAIRS  = 64;
    localparam int CYCLE_LIMIT  = 100_000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    t_cmd    cmd;
    logic    res_valid;
    t_result res;
    int      fail_count;
    int      pending;
    int      burst_left = 0;
    int      cycle_count = 0;

    two_class_fifo_oldest_dequeue dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd),
        .o_valid  (res_valid),
        .o_result (res)
    );

    tcfq_order_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_valid      (res_valid),
        .i_result     (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(input logic [1:0] op, input logic k,
                                      input logic [AGE_W-1:0] a);
        t_cmd c;
        c.operation = op;
        c.kind      = k;
        c.age       = a;
        return c;
    endfunction

    function automatic logic any_kind();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [AGE_W-1:0] any_age();
        return AGE_W'($urandom);
    endfunction

    // one beat; opens a new burst after a random gap when the last one ran out
    task automatic issue(input t_cmd c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        burst_left--;
    endtask

    task automatic random_phase(input int enq_pct, input int cat_pct);
        logic [1:0] op;
        logic       k;
        repeat (100) begin
            k = ($urandom_range(0, 99) < cat_pct) ? KIND_CAT : KIND_DOG;
            if ($urandom_range(0, 99) < enq_pct) begin
                op = OP_ENQ;
            end else begin
                case ($urandom_range(0, 2))
                    0:       op = OP_DEQ_ANY;
                    1:       op = OP_DEQ_C0;
                    default: op = OP_DEQ_C1;
                endcase
            end
            issue(make_cmd(op, k, any_age()));
        end
    endtask

    initial begin
        int enq_pct;
        int cat_pct;
        start <= 1'b0;
        cmd   <= '0;
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty dequeues of every flavor
        issue(make_cmd(OP_DEQ_ANY, KIND_DOG, 10'h3FF));
        issue(make_cmd(OP_DEQ_C0, KIND_CAT, 10'h000));
        issue(make_cmd(OP_DEQ_C1, KIND_DOG, 10'h2AA));
        // oldest first across classes, age extremes
        issue(make_cmd(OP_ENQ, KIND_CAT, 10'h3FF));
        issue(make_cmd(OP_ENQ, KIND_DOG, 10'h000));
        issue(make_cmd(OP_DEQ_ANY, KIND_DOG, 10'h155));
        issue(make_cmd(OP_DEQ_ANY, KIND_CAT, 10'h2AA));
        // class dequeues ignore the kind field
        issue(make_cmd(OP_ENQ, KIND_DOG, 10'h2AA));
        issue(make_cmd(OP_ENQ, KIND_CAT, 10'h155));
        issue(make_cmd(OP_DEQ_C1, KIND_DOG, 10'h3FF));
        issue(make_cmd(OP_DEQ_C0, KIND_CAT, 10'h000));
        // fill one class, then one more gets rejected
        repeat (CLASS_DEPTH + 1) issue(make_cmd(OP_ENQ, KIND_CAT, any_age()));

        for (int p = 0; p < RANDOM_ITEMS / 100; p++) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 75;
                1:       enq_pct = 25;
                default: enq_pct = 50;
            endcase
            if ($urandom_range(0, 3) == 0)
                cat_pct = $urandom_range(0, 1) ? 90 : 10;
            else
                cat_pct = 50;
            random_phase(enq_pct, cat_pct);
        end

        // drain, preload both classes, then churn starting with both classes holding entries
        repeat (2 * CLASS_DEPTH) issue(make_cmd(OP_DEQ_ANY, any_kind(), any_age()));
        repeat (4) begin
            issue(make_cmd(OP_ENQ, KIND_DOG, any_age()));
            issue(make_cmd(OP_ENQ, KIND_CAT, any_age()));
        end
        repeat (CHURN_PAIRS) begin
            issue(make_cmd(OP_ENQ, any_kind(), any_age()));
            issue(make_cmd(OP_DEQ_ANY, any_kind(), any_age()));
        end

        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
